// ----- hw/rtl/swcs_pkg.sv -----
package swcs_pkg;

    localparam int SEQ_W       = 31;
    localparam int NOW_W       = 32;
    localparam int WIN_W       = 6;
    localparam int THR_W       = 7;
    localparam int TMO_W       = 16;
    localparam int CFG_W       = 31;
    localparam int IDX_W       = 2;
    localparam int STAMP_DEPTH = 32;
    localparam int SLOT_W      = 5;

    localparam logic [WIN_W-1:0] WINDOW_MAX    = 6'd32;
    localparam logic [THR_W-1:0] THRESH_RESET  = 7'd64;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd30;

    localparam logic [1:0] MODE_ACK     = 2'd0;
    localparam logic [1:0] MODE_FIN_ACK = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_RETX = 2'd1;
    localparam logic [1:0] ACT_FIN  = 2'd2;
    localparam logic [1:0] ACT_DONE = 2'd3;

    localparam logic [IDX_W-1:0] REG_TOTAL_PACKETS = 2'd0;
    localparam logic [IDX_W-1:0] REG_INIT_THRESH   = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT_MS    = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [SEQ_W-1:0] ack_number;
        logic [NOW_W-1:0] now_ms;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEQ_W-1:0] sequence_res;
        logic             last;
    } out_beat_t;

    typedef struct packed {
        logic             push;
        logic             flush;
        logic [1:0]       action;
        logic [SEQ_W-1:0] seq;
    } res_cmd_t;

    typedef struct packed {
        logic room;
        logic pend_valid;
    } res_stat_t;

endpackage

// ----- hw/rtl/swcs_chan_if.sv -----
interface swcs_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- hw/rtl/swcs_ram.sv -----
module swcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/swcs_alu.sv -----
module swcs_alu
    import swcs_pkg::*;
(
    input  logic [NOW_W-1:0] a,
    input  logic [NOW_W-1:0] b,
    output logic [NOW_W-1:0] diff,
    output logic             lt,
    output logic             eq
);

    logic [NOW_W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[NOW_W-1:0];
    assign lt   = wide[NOW_W];
    assign eq   = (a == b);

endmodule

// ----- hw/rtl/swcs_out.sv -----
module swcs_out
    import swcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  res_cmd_t    cmd,
    output res_stat_t   stat,
    swcs_chan_if.source result
);

    // One result is held back so that the last flag is known when it leaves.
    logic             pend_valid_reg, pend_valid_next;
    logic [1:0]       pend_action_reg, pend_action_next;
    logic [SEQ_W-1:0] pend_seq_reg, pend_seq_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_data_reg, out_data_next;
    logic             out_free;
    logic             room;

    assign out_free = !out_valid_reg || result.ready;
    assign room     = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_action_next = pend_action_reg;
        pend_seq_next    = pend_seq_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_data_next    = out_data_reg;
        if (cmd.push && room)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{action: pend_action_reg, sequence_res: pend_seq_reg,
                                   last: 1'b0};
            end
            pend_valid_next  = 1'b1;
            pend_action_next = cmd.action;
            pend_seq_next    = cmd.seq;
        end
        else if (cmd.flush && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = '{action: pend_action_reg, sequence_res: pend_seq_reg,
                                last: 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_action_reg <= pend_action_next;
        pend_seq_reg    <= pend_seq_next;
        out_data_reg    <= out_data_next;
    end

    assign stat.room       = room;
    assign stat.pend_valid = pend_valid_reg;
    assign result.valid    = out_valid_reg;
    assign result.data     = out_data_reg;

endmodule

// ----- hw/rtl/sliding_window_congestion_sender_core.sv -----
// Channel     Dir   Beat fields                          Accepted when
// in_item     in    mode, ack_number, now_ms             valid && ready
// out_result  out   action, sequence_res, last           valid && ready
// cfg         in    cfg_index, cfg_data                  cfg_write
//
// An event is taken while idle and then holds ready low while a sequencer drives one
// shared subtract and compare unit; once finished, events are taken and dropped. Each
// new send takes a check step and a send step, and one more check ends the sends. An
// ACK then checks the total and the base and retires acked packets; a timeout checks,
// ages and compares each outstanding stamp. A flush step releases the final result.
// Stalls on out_result hold each result step; one result waits in a holding slot.
// Reset clears all control state; the stamp memory needs no clearing pass.
module sliding_window_congestion_sender_core
    import swcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    swcs_chan_if.sink        in_item,
    swcs_chan_if.source      out_result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND_CHK,
        ST_SEND,
        ST_EV,
        ST_EV_BASE,
        ST_RETIRE,
        ST_TO_CHK,
        ST_TO_AGE,
        ST_TO_CMP,
        ST_TO_END,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [SEQ_W-1:0] total_reg, total_next;
    logic [TMO_W-1:0] timeout_reg, timeout_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic [THR_W-1:0] threshold_reg, threshold_next;
    logic [SEQ_W-1:0] next_sequence_reg, next_sequence_next;
    logic [SEQ_W-1:0] base_sequence_reg, base_sequence_next;
    logic [WIN_W-1:0] outstanding_reg, outstanding_next;
    logic [1:0]       dup_count_reg, dup_count_next;
    logic             finished_reg, finished_next;
    logic [WIN_W-1:0] walk_idx_reg, walk_idx_next;
    logic             any_reg, any_next;

    logic [1:0]       mode_reg, mode_next;
    logic [SEQ_W-1:0] ack_reg, ack_next;
    logic [NOW_W-1:0] now_reg, now_next;
    logic [SEQ_W-1:0] walk_seq_reg, walk_seq_next;
    logic [NOW_W-1:0] age_reg, age_next;

    logic [NOW_W-1:0]  alu_a, alu_b, alu_diff;
    logic              alu_lt, alu_eq;
    res_cmd_t          res_cmd;
    res_stat_t         res_stat;
    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr;
    logic [NOW_W-1:0]  ram_rdata;
    logic [THR_W-1:0]  win_ext, grow_w;
    logic [WIN_W-1:0]  half_w;
    logic              outst_nz;

    swcs_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .lt   (alu_lt),
        .eq   (alu_eq)
    );

    swcs_ram #(
        .WIDTH (NOW_W),
        .DEPTH (STAMP_DEPTH)
    ) u_stamps (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .re    (ram_re),
        .raddr (walk_seq_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    swcs_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (res_cmd),
        .stat   (res_stat),
        .result (out_result)
    );

    assign in_item.ready = (state_reg == ST_IDLE);
    assign outst_nz      = (outstanding_reg != '0);
    assign ram_waddr     = (state_reg == ST_SEND) ? next_sequence_reg[SLOT_W-1:0]
                                                  : walk_seq_reg[SLOT_W-1:0];

    always_comb
    begin
        win_ext = {1'b0, window_reg};
        grow_w  = (win_ext < threshold_reg) ? {window_reg, 1'b0} : win_ext + 7'd1;
        if (grow_w > {1'b0, WINDOW_MAX})
        begin
            grow_w = {1'b0, WINDOW_MAX};
        end
        half_w = window_reg >> 1;
        if (half_w == '0)
        begin
            half_w = 6'd1;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_SEND_CHK:
            begin
                alu_a = NOW_W'(next_sequence_reg);
                alu_b = NOW_W'(total_reg);
            end
            ST_EV:
            begin
                alu_a = NOW_W'(ack_reg);
                alu_b = NOW_W'(total_reg);
            end
            ST_EV_BASE, ST_RETIRE:
            begin
                alu_a = NOW_W'(base_sequence_reg);
                alu_b = NOW_W'(ack_reg);
            end
            ST_TO_AGE:
            begin
                alu_a = now_reg;
                alu_b = ram_rdata;
            end
            ST_TO_CMP:
            begin
                alu_a = NOW_W'(timeout_reg);
                alu_b = age_reg;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        total_next         = total_reg;
        timeout_next       = timeout_reg;
        window_next        = window_reg;
        threshold_next     = threshold_reg;
        next_sequence_next = next_sequence_reg;
        base_sequence_next = base_sequence_reg;
        outstanding_next   = outstanding_reg;
        dup_count_next     = dup_count_reg;
        finished_next      = finished_reg;
        walk_idx_next      = walk_idx_reg;
        any_next           = any_reg;
        mode_next          = mode_reg;
        ack_next           = ack_reg;
        now_next           = now_reg;
        walk_seq_next      = walk_seq_reg;
        age_next           = age_reg;
        res_cmd            = '0;
        ram_we             = 1'b0;
        ram_re             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_item.valid)
                begin
                    mode_next = in_item.data.mode;
                    ack_next  = in_item.data.ack_number;
                    now_next  = in_item.data.now_ms;
                    if (!finished_reg)
                    begin
                        state_next = ST_SEND_CHK;
                    end
                end
            end
            ST_SEND_CHK:
            begin
                if ((outstanding_reg < window_reg) && alu_lt)
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    state_next = ST_EV;
                end
            end
            ST_SEND:
            begin
                res_cmd.push   = 1'b1;
                res_cmd.action = ACT_SEND;
                res_cmd.seq    = next_sequence_reg;
                if (res_stat.room)
                begin
                    ram_we             = 1'b1;
                    next_sequence_next = next_sequence_reg + 31'd1;
                    outstanding_next   = outstanding_reg + 6'd1;
                    state_next         = ST_SEND_CHK;
                end
            end
            ST_EV:
            begin
                unique case (mode_reg)
                    MODE_FIN_ACK:
                    begin
                        res_cmd.push   = 1'b1;
                        res_cmd.action = ACT_DONE;
                        if (res_stat.room)
                        begin
                            finished_next = 1'b1;
                            state_next    = ST_FLUSH;
                        end
                    end
                    MODE_ACK:
                    begin
                        if (alu_eq)
                        begin
                            res_cmd.push   = 1'b1;
                            res_cmd.action = ACT_FIN;
                            if (res_stat.room)
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        else
                        begin
                            state_next = ST_EV_BASE;
                        end
                    end
                    MODE_TIMEOUT:
                    begin
                        walk_idx_next = '0;
                        walk_seq_next = base_sequence_reg;
                        any_next      = 1'b0;
                        state_next    = ST_TO_CHK;
                    end
                    default:
                    begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end
            ST_EV_BASE:
            begin
                if (outst_nz && alu_lt)
                begin
                    state_next = ST_RETIRE;
                end
                else if (outst_nz && alu_eq)
                begin
                    if (dup_count_reg == 2'd2)
                    begin
                        res_cmd.push   = 1'b1;
                        res_cmd.action = ACT_RETX;
                        res_cmd.seq    = base_sequence_reg;
                        if (res_stat.room)
                        begin
                            window_next    = half_w;
                            threshold_next = THR_W'(half_w);
                            dup_count_next = '0;
                            state_next     = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        dup_count_next = dup_count_reg + 2'd1;
                        state_next     = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_RETIRE:
            begin
                if (outst_nz && alu_lt)
                begin
                    base_sequence_next = base_sequence_reg + 31'd1;
                    outstanding_next   = outstanding_reg - 6'd1;
                end
                else
                begin
                    dup_count_next = '0;
                    window_next    = grow_w[WIN_W-1:0];
                    state_next     = ST_FLUSH;
                end
            end
            ST_TO_CHK:
            begin
                if (walk_idx_reg < outstanding_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_TO_AGE;
                end
                else
                begin
                    state_next = ST_TO_END;
                end
            end
            ST_TO_AGE:
            begin
                age_next   = alu_diff;
                ram_we     = 1'b1;
                state_next = ST_TO_CMP;
            end
            ST_TO_CMP:
            begin
                if (alu_lt)
                begin
                    res_cmd.push   = 1'b1;
                    res_cmd.action = ACT_RETX;
                    res_cmd.seq    = walk_seq_reg;
                    if (res_stat.room)
                    begin
                        any_next      = 1'b1;
                        walk_idx_next = walk_idx_reg + 6'd1;
                        walk_seq_next = walk_seq_reg + 31'd1;
                        state_next    = ST_TO_CHK;
                    end
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + 6'd1;
                    walk_seq_next = walk_seq_reg + 31'd1;
                    state_next    = ST_TO_CHK;
                end
            end
            ST_TO_END:
            begin
                if (any_reg)
                begin
                    window_next    = 6'd1;
                    threshold_next = threshold_reg >> 1;
                end
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                res_cmd.flush = 1'b1;
                if (res_stat.room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TOTAL_PACKETS: total_next     = cfg_data[SEQ_W-1:0];
                REG_INIT_THRESH:   threshold_next = cfg_data[THR_W-1:0];
                REG_TIMEOUT_MS:    timeout_next   = cfg_data[TMO_W-1:0];
                default:           total_next     = total_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            total_reg         <= '0;
            timeout_reg       <= TIMEOUT_RESET;
            window_reg        <= 6'd1;
            threshold_reg     <= THRESH_RESET;
            next_sequence_reg <= '0;
            base_sequence_reg <= '0;
            outstanding_reg   <= '0;
            dup_count_reg     <= '0;
            finished_reg      <= 1'b0;
            walk_idx_reg      <= '0;
            any_reg           <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            total_reg         <= total_next;
            timeout_reg       <= timeout_next;
            window_reg        <= window_next;
            threshold_reg     <= threshold_next;
            next_sequence_reg <= next_sequence_next;
            base_sequence_reg <= base_sequence_next;
            outstanding_reg   <= outstanding_next;
            dup_count_reg     <= dup_count_next;
            finished_reg      <= finished_next;
            walk_idx_reg      <= walk_idx_next;
            any_reg           <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        ack_reg      <= ack_next;
        now_reg      <= now_next;
        walk_seq_reg <= walk_seq_next;
        age_reg      <= age_next;
    end

    a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
        (next_sequence_reg - base_sequence_reg) == SEQ_W'(outstanding_reg))
        else $error("outstanding count disagrees with the sequence span");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (window_reg != '0) && (window_reg <= WINDOW_MAX))
        else $error("window out of range");

    a_outst_range: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= WINDOW_MAX)
        else $error("outstanding exceeds the window limit");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !res_stat.pend_valid)
        else $error("result left in the holding slot while idle");

endmodule
